// ----- src/cga_pkg.sv -----
// ----------------------------------------------------------------------------
// cga_pkg
// shared constants, types and helpers of the composite color decoder
// ----------------------------------------------------------------------------
package cga_pkg;

    localparam int MAX_LINE_PIXELS = 2048;
    localparam int POS_W     = $clog2(MAX_LINE_PIXELS);
    localparam int WIN       = 11;
    localparam int CNT_W     = $clog2(MAX_LINE_PIXELS + WIN);
    localparam int HOLD_CNT  = WIN + 6;
    localparam int TBL_DEPTH = 1024;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int SMP_W     = 12;
    localparam int COL_W     = 4;
    localparam int SHARP_W   = 11;
    localparam int COEF_W    = 16;
    localparam int DW        = 20;
    localparam int YP_W      = SHARP_W + DW;
    localparam int CP_W      = COEF_W + DW;
    localparam int WIDE      = CP_W + 2;
    localparam int SHIFT     = 13;
    localparam int CH_W      = 8;
    localparam int STEP_W    = 4;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TABLE = 1'b1;

    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PIXEL = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RIGHT = 4'd5;
    localparam logic [STEP_W-1:0] STEP_EOL   = 4'd10;

    localparam logic [CFG_AW-1:0] REG_MONO    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SHARP   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COEF_RI = 3'd2;
    localparam logic [CFG_AW-1:0] REG_COEF_RQ = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COEF_GI = 3'd4;
    localparam logic [CFG_AW-1:0] REG_COEF_GQ = 3'd5;
    localparam logic [CFG_AW-1:0] REG_COEF_BI = 3'd6;
    localparam logic [CFG_AW-1:0] REG_COEF_BQ = 3'd7;

    typedef struct packed {
        logic                     valid;
        logic                     wr;
        logic                     dec;
        logic                     eol;
        logic                     hold;
        logic [1:0]               phase;
        logic [TBL_AW-1:0]        addr;
        logic signed [SMP_W-1:0]  data;
    } op_t;

    typedef struct packed {
        logic                      mono;
        logic signed [SHARP_W-1:0] sharp;
        logic signed [COEF_W-1:0]  ri;
        logic signed [COEF_W-1:0]  rq;
        logic signed [COEF_W-1:0]  gi;
        logic signed [COEF_W-1:0]  gq;
        logic signed [COEF_W-1:0]  bi;
        logic signed [COEF_W-1:0]  bq;
    } cfg_t;

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [WIDE-1:0] v);
        logic [CH_W-1:0] r;
        if (v[WIDE-1])
            r = '0;
        else if (|v[WIDE-2:SHIFT+CH_W])
            r = '1;
        else
            r = v[SHIFT+CH_W-1:SHIFT];
        return r;
    endfunction

endpackage

// ----- src/cga_if.sv -----
// ----------------------------------------------------------------------------
// cga_if
// handshake channels of the composite color decoder
// ----------------------------------------------------------------------------
interface cga_in_if;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [3:0]             color;
    logic [3:0]             border;
    logic                   last;
    logic [9:0]             table_index;
    logic signed [11:0]     table_value;

    modport source (output valid, kind, color, border, last, table_index, table_value,
                    input ready);
    modport sink   (input valid, kind, color, border, last, table_index, table_value,
                    output ready);
endinterface

interface cga_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_line;

    modport source (output valid, red, green, blue, end_of_line, input ready);
    modport sink   (input valid, red, green, blue, end_of_line, output ready);
endinterface

interface cga_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cga_ram.sv -----
// ----------------------------------------------------------------------------
// cga_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cga_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/cga_seq.sv -----
// ----------------------------------------------------------------------------
// cga_seq
// line sequencer: turns pixels into table reads and table words into writes
// ----------------------------------------------------------------------------
module cga_seq import cga_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    cga_in_if.sink pix_in,
    input  logic   en,
    output op_t    op,
    output logic   release_pulse
);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  bl_reg;
    logic [COL_W-1:0]  prev_reg;
    logic              lst_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              pend_reg;
    op_t               op_reg;

    logic              slot_free;
    logic              acc;
    logic              acc_pix;
    logic              first;
    logic              load;
    logic [STEP_W-1:0] step;
    logic [COL_W-1:0]  cur_col;
    logic [COL_W-1:0]  cur_bl;
    logic              cur_first;
    logic              cur_lst;
    logic [STEP_W-1:0] end_step;
    logic [CNT_W-1:0]  cnt_next;
    op_t               op_next;

    always_comb
    begin
        slot_free    = !op_reg.valid || en;
        pix_in.ready = !busy_reg && slot_free;
        acc          = pix_in.valid && pix_in.ready;
        acc_pix      = acc && (pix_in.kind == KIND_PIXEL);
        first        = (pos_reg == '0);
        load         = acc_pix || (busy_reg && slot_free);

        if (busy_reg)
        begin
            step      = step_reg;
            cur_col   = col_reg;
            cur_bl    = bl_reg;
            cur_first = 1'b1;
            cur_lst   = lst_reg;
        end
        else
        begin
            step      = first ? STEP_FIRST : STEP_PIXEL;
            cur_col   = pix_in.color;
            cur_bl    = first ? pix_in.border : bl_reg;
            cur_first = first;
            cur_lst   = pix_in.last || (pos_reg >= POS_W'(MAX_LINE_PIXELS - 1));
        end

        end_step = cur_lst ? STEP_EOL : STEP_PIXEL;
        cnt_next = (step == STEP_FIRST) ? CNT_W'(1) : cnt_reg + CNT_W'(1);

        op_next       = '0;
        op_next.valid = 1'b1;
        op_next.wr    = 1'b0;
        op_next.dec   = (cnt_next >= CNT_W'(WIN));
        op_next.eol   = (step == STEP_EOL);
        op_next.hold  = (step == STEP_EOL) && (cnt_next >= CNT_W'(HOLD_CNT));
        op_next.phase = cnt_next[1:0] + 2'd1;
        op_next.data  = '0;
        if (step < STEP_PIXEL)
            op_next.addr = {cur_bl, cur_bl, step[1:0] + 2'd3};
        else if (step == STEP_PIXEL)
            op_next.addr = cur_first ? {cur_bl, cur_col, 2'd3}
                                     : {prev_reg, cur_col, pos_reg[1:0] - 2'd1};
        else if (step == STEP_RIGHT)
            op_next.addr = {cur_col, cur_bl, 2'd3};
        else
            op_next.addr = {cur_bl, cur_bl, step[1:0] - 2'd2};

        if (acc && (pix_in.kind == KIND_TABLE))
        begin
            op_next.wr   = 1'b1;
            op_next.dec  = 1'b0;
            op_next.eol  = 1'b0;
            op_next.hold = 1'b0;
            op_next.addr = pix_in.table_index;
            op_next.data = pix_in.table_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            col_reg  <= '0;
            bl_reg   <= '0;
            prev_reg <= '0;
            lst_reg  <= 1'b0;
            pos_reg  <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            op_reg   <= '0;
        end
        else
        begin
            if (acc && !acc_pix)
            begin
                op_reg <= op_next;
            end
            else if (load)
            begin
                op_reg  <= op_next;
                cnt_reg <= cnt_next;
                if (step == end_step)
                    busy_reg <= 1'b0;
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= step + STEP_W'(1);
                end
                if (op_next.hold)
                    pend_reg <= 1'b1;
            end
            else if (en)
            begin
                op_reg.valid <= 1'b0;
            end

            if (acc)
            begin
                pend_reg <= 1'b0;
            end

            if (acc_pix)
            begin
                col_reg  <= pix_in.color;
                prev_reg <= pix_in.color;
                lst_reg  <= cur_lst;
                bl_reg   <= cur_bl;
                pos_reg  <= cur_lst ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    assign op            = op_reg;
    assign release_pulse = acc && pend_reg;

endmodule

// ----- src/cga_dec.sv -----
// ----------------------------------------------------------------------------
// cga_dec
// table memory, sample window, chroma/luma filters, matrix and output stage
// ----------------------------------------------------------------------------
module cga_dec import cga_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    input  cfg_t       cfg,
    input  logic       release_ok,
    output logic       en,
    output logic       held_taken,
    cga_out_if.source  pix_out
);

    typedef struct packed {
        logic              dec;
        logic              eol;
        logic              hold;
        logic [1:0]        phase;
        logic [TBL_AW-1:0] addr;
    } s1_t;

    logic [SMP_W-1:0]        rd_data;
    logic [TBL_AW-1:0]       rd_addr;
    logic                    s1_valid_reg;
    s1_t                     s1_reg;
    logic signed [SMP_W-1:0] win_reg [WIN];

    logic                    s2_valid_reg, s2_eol_reg, s2_hold_reg;
    logic [1:0]              s2_phase_reg;

    logic                    s3_valid_reg, s3_eol_reg, s3_hold_reg, s3_mono_reg;
    logic signed [DW-1:0]    s3_c_reg, s3_d_reg, s3_ci_reg, s3_cq_reg;

    logic                    s4_valid_reg, s4_eol_reg, s4_hold_reg;
    logic signed [DW+8-1:0]  s4_ysh_reg;
    logic signed [YP_W-1:0]  s4_yp_reg;
    logic signed [CP_W-1:0]  s4_ri_reg, s4_rq_reg, s4_gi_reg, s4_gq_reg, s4_bi_reg, s4_bq_reg;

    logic                    s5_valid_reg, s5_eol_reg, s5_hold_reg;
    logic signed [WIDE-1:0]  s5_y_reg, s5_r_reg, s5_g_reg, s5_b_reg;

    logic                    out_valid_reg, out_hold_reg, out_eol_reg;
    logic [CH_W-1:0]         out_r_reg, out_g_reg, out_b_reg;

    logic signed [DW-1:0]    t [WIN];
    logic signed [DW-1:0]    am, a0, ap, b0, c, d, ci, cq;
    logic signed [DW-1:0]    diff;
    logic                    out_take;

    always_comb
    begin
        pix_out.valid       = out_valid_reg && (!out_hold_reg || release_ok);
        pix_out.red         = out_r_reg;
        pix_out.green       = out_g_reg;
        pix_out.blue        = out_b_reg;
        pix_out.end_of_line = out_eol_reg;
        out_take            = pix_out.valid && pix_out.ready;
        en                  = !out_valid_reg || out_take;
        held_taken          = out_take && out_hold_reg;
        rd_addr             = en ? op.addr : s1_reg.addr;
    end

    cga_ram #(
        .WIDTH (SMP_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (op.valid && op.wr && en),
        .waddr (op.addr),
        .wdata (op.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // chroma a/b, luma terms and phase rotation
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            t[i] = DW'(win_reg[i]);
        end
        am = t[0] - ((t[2] - t[4] + t[6]) <<< 1) + t[8];
        a0 = t[1] - ((t[3] - t[5] + t[7]) <<< 1) + t[9];
        ap = t[2] - ((t[4] - t[6] + t[8]) <<< 1) + t[10];
        b0 = (t[2] - t[4] + t[6] - t[8]) <<< 1;
        if (cfg.mono)
        begin
            c = t[5] <<< 4;
            d = (t[4] + t[6]) <<< 3;
        end
        else
        begin
            c = ((t[5] <<< 3) - a0) <<< 1;
            d = ((t[4] <<< 3) - am) + ((t[6] <<< 3) - ap);
        end
        case (s2_phase_reg)
            2'd0:
            begin
                ci = a0;
                cq = b0;
            end
            2'd1:
            begin
                ci = -b0;
                cq = a0;
            end
            2'd2:
            begin
                ci = -a0;
                cq = -b0;
            end
            default:
            begin
                ci = b0;
                cq = -a0;
            end
        endcase
        diff = s3_c_reg - s3_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.dec   <= op.dec;
            s1_reg.eol   <= op.eol;
            s1_reg.hold  <= op.hold;
            s1_reg.phase <= op.phase;
            s1_reg.addr  <= op.addr;

            if (s1_valid_reg)
            begin
                for (int i = 0; i < WIN - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN-1] <= rd_data;
            end

            s2_eol_reg   <= s1_reg.eol;
            s2_hold_reg  <= s1_reg.hold;
            s2_phase_reg <= s1_reg.phase;

            s3_eol_reg  <= s2_eol_reg;
            s3_hold_reg <= s2_hold_reg;
            s3_mono_reg <= cfg.mono;
            s3_c_reg    <= c;
            s3_d_reg    <= d;
            s3_ci_reg   <= ci;
            s3_cq_reg   <= cq;

            s4_eol_reg  <= s3_eol_reg;
            s4_hold_reg <= s3_hold_reg;
            s4_ysh_reg  <= (DW+8)'(s3_c_reg + s3_d_reg) <<< 8;
            s4_yp_reg   <= cfg.sharp * diff;
            if (s3_mono_reg)
            begin
                s4_ri_reg <= '0;
                s4_rq_reg <= '0;
                s4_gi_reg <= '0;
                s4_gq_reg <= '0;
                s4_bi_reg <= '0;
                s4_bq_reg <= '0;
            end
            else
            begin
                s4_ri_reg <= cfg.ri * s3_ci_reg;
                s4_rq_reg <= cfg.rq * s3_cq_reg;
                s4_gi_reg <= cfg.gi * s3_ci_reg;
                s4_gq_reg <= cfg.gq * s3_cq_reg;
                s4_bi_reg <= cfg.bi * s3_ci_reg;
                s4_bq_reg <= cfg.bq * s3_cq_reg;
            end

            s5_eol_reg  <= s4_eol_reg;
            s5_hold_reg <= s4_hold_reg;
            s5_y_reg    <= WIDE'(s4_ysh_reg) + WIDE'(s4_yp_reg);
            s5_r_reg    <= WIDE'(s4_ri_reg) + WIDE'(s4_rq_reg);
            s5_g_reg    <= WIDE'(s4_gi_reg) + WIDE'(s4_gq_reg);
            s5_b_reg    <= WIDE'(s4_bi_reg) + WIDE'(s4_bq_reg);

            out_eol_reg <= s5_eol_reg;
            out_r_reg   <= clamp_ch(s5_y_reg + s5_r_reg);
            out_g_reg   <= clamp_ch(s5_y_reg + s5_g_reg);
            out_b_reg   <= clamp_ch(s5_y_reg + s5_b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hold_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= op.valid && !op.wr;
            s2_valid_reg  <= s1_valid_reg && s1_reg.dec;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
            out_hold_reg  <= s5_valid_reg && s5_hold_reg;
        end
    end

endmodule

// ----- src/cga_composite_decoder_top.sv -----
// ----------------------------------------------------------------------------
// cga_composite_decoder_top
// composite scanline decoder: pixel colors in, decoded rgb pixels out
// ----------------------------------------------------------------------------
// Mid-line pixels and table word writes are taken one per clock unless the
// output stalls. The first and last pixels of a line hold the input while
// extra border and flush samples are read, since each composite sample is one
// read of the 1024-word table through its single read port. A decoded pixel
// is presented once the transaction or flush step that reads its last sample
// has passed the table read, stages s2 to s5 and the output register. The
// end-of-line pixel of a line of seven or more pixels is released only once
// the next transaction is accepted on the input. The table has no reset:
// every word must be written before a pixel uses it. Configuration is written
// through cfg at any time the block is idle and is always ready.
// ----------------------------------------------------------------------------
module cga_composite_decoder_top import cga_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    cga_in_if.sink     pix_in,
    cga_out_if.source  pix_out,
    cga_cfg_if.sink    cfg
);

    cfg_t cfg_reg;
    logic release_reg;
    logic release_pulse;
    logic held_taken;
    logic en;
    op_t  op;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            release_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_MONO:    cfg_reg.mono  <= cfg.data[0];
                    REG_SHARP:   cfg_reg.sharp <= cfg.data[SHARP_W-1:0];
                    REG_COEF_RI: cfg_reg.ri    <= cfg.data;
                    REG_COEF_RQ: cfg_reg.rq    <= cfg.data;
                    REG_COEF_GI: cfg_reg.gi    <= cfg.data;
                    REG_COEF_GQ: cfg_reg.gq    <= cfg.data;
                    REG_COEF_BI: cfg_reg.bi    <= cfg.data;
                    REG_COEF_BQ: cfg_reg.bq    <= cfg.data;
                    default:     cfg_reg       <= cfg_reg;
                endcase
            end
            if (release_pulse)
                release_reg <= 1'b1;
            else if (held_taken)
                release_reg <= 1'b0;
        end
    end

    cga_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_in        (pix_in),
        .en            (en),
        .op            (op),
        .release_pulse (release_pulse)
    );

    cga_dec u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .cfg        (cfg_reg),
        .release_ok (release_reg),
        .en         (en),
        .held_taken (held_taken),
        .pix_out    (pix_out)
    );

endmodule
